/* rtl/ipr_pkg.sv */
// shared types and constants for the isolated pixel removal and fill block
`default_nettype none

package ipr_pkg;

  localparam int MAX_WIDTH = 256;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);

  localparam int PIX_W = 8;
  localparam int FW_W = 9;
  localparam int FH_W = 12;
  localparam int ROW_W = 12;
  localparam int STORE_W = 2 * PIX_W;
  localparam int MIN_DIM = 3;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE = 2'd2;

  localparam logic [FW_W-1:0] FW_RESET = 9'd256;
  localparam logic [FH_W-1:0] FH_RESET = 12'd256;
  localparam logic [PIX_W-1:0] FILL_RESET = 8'd5;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic             opcode;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [ROW_W-1:0] height;
  } geom_t;

  // one classified transaction for the back end
  typedef struct packed {
    logic             is_flush;
    logic             emit;
    logic             use_corner;
    logic             border;
    logic             sel_mid;
    logic             last;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] corner_col;
    logic [PIX_W-1:0] px;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/ipr_ram.sv */
// generic single-write dual-read ram with registered read data
`default_nettype none

module ipr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [WIDTH-1:0]  rdata_a,
  output logic      [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read during write returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

/* rtl/ipr_front.sv */
// front end: position tracking and classification of each input transaction
`default_nettype none

module ipr_front import ipr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire geom_t    geom,
  input  wire logic     accept,
  input  wire in_item_t item,
  output logic          push,
  output cmd_t          cmd
);

  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;

  logic             wrap;
  logic [ROW_W-1:0] row_pre;
  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c;
  logic [WID_W-1:0] c_plus;
  logic             c_end;
  logic [ROW_W-1:0] r_plus;
  logic             r_end;
  logic             emit;
  logic [COL_W-1:0] wlast;
  logic [ROW_W-1:0] orow;
  logic [COL_W-1:0] ocol;
  logic [WID_W-1:0] ocol_plus;
  logic             ocol_end;
  logic [ROW_W-1:0] orow_plus;
  logic             orow_end;
  logic             border;
  logic [WID_W-1:0] f_col_plus;
  logic             f_col_end;
  logic [ROW_W-1:0] f_row_plus;
  logic             f_row_end;
  logic             flush_ok;
  logic             is_flush;

  // position of this pixel after wrapping a counter that a size change left out of range
  assign wrap    = WID_W'(in_col_r) >= geom.width;
  assign row_pre = wrap ? ROW_W'(in_row_r + ROW_W'(1)) : in_row_r;
  assign r       = (row_pre >= geom.height) ? '0 : row_pre;
  assign c       = wrap ? '0 : in_col_r;

  assign c_plus = WID_W'(c) + WID_W'(1);
  assign c_end  = c_plus >= geom.width;
  assign r_plus = ROW_W'(r + ROW_W'(1));
  assign r_end  = r_plus >= geom.height;

  assign emit  = (r >= ROW_W'(2)) || ((r == ROW_W'(1)) && (c != '0));
  assign wlast = COL_W'(geom.width - WID_W'(1));

  // column zero releases the last pixel of the row two above
  assign orow = (c == '0) ? ROW_W'(r - ROW_W'(2)) : ROW_W'(r - ROW_W'(1));
  assign ocol = (c == '0) ? wlast : COL_W'(c - COL_W'(1));

  assign ocol_plus = WID_W'(ocol) + WID_W'(1);
  assign ocol_end  = ocol_plus >= geom.width;
  assign orow_plus = ROW_W'(orow + ROW_W'(1));
  assign orow_end  = orow_plus >= geom.height;
  assign border    = (orow == '0) || orow_end || (ocol == '0) || ocol_end;

  assign f_col_plus = WID_W'(out_col_r) + WID_W'(1);
  assign f_col_end  = f_col_plus >= geom.width;
  assign f_row_plus = ROW_W'(out_row_r + ROW_W'(1));
  assign f_row_end  = f_row_plus >= geom.height;

  // drain only between frames and only while results are pending
  assign flush_ok = (in_row_r == '0) && (in_col_r == '0) &&
                    ((out_row_r != '0) || (out_col_r != '0));

  assign is_flush = item.opcode == OP_FLUSH;
  assign push     = accept && (!is_flush || flush_ok);

  always_comb begin
    cmd.is_flush   = is_flush;
    cmd.emit       = is_flush ? 1'b1 : emit;
    cmd.use_corner = c == '0;
    cmd.border     = border;
    cmd.sel_mid    = f_row_end;
    cmd.last       = is_flush ? (f_row_end && f_col_end) : (orow_end && ocol_end);
    cmd.col        = is_flush ? out_col_r : c;
    cmd.corner_col = wlast;
    cmd.px         = item.pixel_in;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (accept) begin
      if (is_flush) begin
        if (flush_ok) begin
          if (f_col_end) begin
            out_col_nxt = '0;
            out_row_nxt = f_row_end ? '0 : f_row_plus;
          end else begin
            out_col_nxt = COL_W'(f_col_plus);
          end
        end
      end else begin
        if ((r == '0) && (c == '0)) begin
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        if (emit) begin
          if (ocol_end) begin
            out_col_nxt = '0;
            out_row_nxt = orow_plus;
          end else begin
            out_col_nxt = COL_W'(ocol_plus);
            out_row_nxt = orow;
          end
        end
        if (c_end) begin
          in_col_nxt = '0;
          in_row_nxt = r_end ? '0 : r_plus;
        end else begin
          in_col_nxt = COL_W'(c_plus);
          in_row_nxt = r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

`ifndef SYNTH
  // the first pixel of a frame restarts the result position
  a_frame_start_resets_out: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_flush && (r == '0) && (c == '0)) |=>
      ((out_row_r == '0) && (out_col_r == '0)))
    else $error("result position not restarted at frame start");
`endif

endmodule

`default_nettype wire

/* rtl/ipr_cmd_q.sv */
// short command queue between the front end and the back end
`default_nettype none

module ipr_cmd_q import ipr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t cmd_in,
  input  wire logic pop,
  output logic      full,
  output logic      valid,
  output cmd_t      head
);

  cmd_t                  q_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH);
  assign valid = cnt_r != '0;
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 :
                   CMDQ_PTR_W'(wr_ptr_r + CMDQ_PTR_W'(1));
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 :
                   CMDQ_PTR_W'(rd_ptr_r + CMDQ_PTR_W'(1));
    end
    case ({push, pop})
      2'b10:   cnt_nxt = CMDQ_CNT_W'(cnt_r + CMDQ_CNT_W'(1));
      2'b01:   cnt_nxt = CMDQ_CNT_W'(cnt_r - CMDQ_CNT_W'(1));
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("command queue overflow");
`endif

endmodule

`default_nettype wire

/* rtl/ipr_back.sv */
// back end: line stores, 3x3 window, isolated pixel test, fill and result queue
`default_nettype none

module ipr_back import ipr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [PIX_W-1:0] fill,
  input  wire logic             q_valid,
  input  wire cmd_t             q_head,
  output logic                  q_pop,
  input  wire logic             out_pop,
  output logic                  out_empty,
  output out_item_t             out_item
);

  logic                    s1_valid_r;
  cmd_t                    s1_cmd_r;

  logic                    lw_valid_r;
  logic [COL_W-1:0]        lw_addr_r;
  logic [STORE_W-1:0]      lw_data_r;

  logic [STORE_W-1:0]      rdata_a;
  logic [STORE_W-1:0]      rdata_b;
  logic [STORE_W-1:0]      a_data;
  logic [STORE_W-1:0]      b_data;
  logic [PIX_W-1:0]        up;
  logic [PIX_W-1:0]        mid;
  logic [PIX_W-1:0]        corner;

  logic [PIX_W-1:0]        win_r   [9];
  logic [PIX_W-1:0]        win_nxt [9];
  logic                    lone;
  logic [PIX_W-1:0]        cleaned;
  logic [PIX_W-1:0]        pv;
  logic                    is_pix;
  out_item_t               res;

  out_item_t               oq_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]   oq_wr_r, oq_wr_nxt;
  logic [OUTQ_PTR_W-1:0]   oq_rd_r, oq_rd_nxt;
  logic [OUTQ_CNT_W-1:0]   oq_cnt_r, oq_cnt_nxt;
  logic [OUTQ_CNT_W:0]     oq_used;
  logic                    oq_push;
  logic                    oq_pop;

  // reserve a result slot for every transaction in flight
  assign oq_used = {1'b0, oq_cnt_r} + (OUTQ_CNT_W + 1)'(s1_valid_r);
  assign q_pop   = q_valid && (oq_used < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));

  // each entry holds the pixel two rows up (high half) and one row up (low half)
  ipr_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_WIDTH)
  ) u_store (
    .clk     (clk),
    .we      (is_pix),
    .waddr   (s1_cmd_r.col),
    .wdata   ({mid, s1_cmd_r.px}),
    .re      (q_pop),
    .raddr_a (q_head.col),
    .raddr_b (q_head.corner_col),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // bypass the write made at the same edge as the read
  assign a_data = (lw_valid_r && (lw_addr_r == s1_cmd_r.col)) ? lw_data_r : rdata_a;
  assign b_data = (lw_valid_r && (lw_addr_r == s1_cmd_r.corner_col)) ? lw_data_r : rdata_b;
  assign up     = a_data[STORE_W-1 -: PIX_W];
  assign mid    = a_data[PIX_W-1:0];
  assign corner = b_data[STORE_W-1 -: PIX_W];

  assign is_pix = s1_valid_r && !s1_cmd_r.is_flush;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[3*k]     = win_r[3*k + 1];
      win_nxt[3*k + 1] = win_r[3*k + 2];
    end
    win_nxt[2] = up;
    win_nxt[5] = mid;
    win_nxt[8] = s1_cmd_r.px;
  end

  always_comb begin
    lone = 1'b1;
    for (int k = 0; k < 9; k++) begin
      if ((k != 4) && (win_nxt[k] != '0)) begin
        lone = 1'b0;
      end
    end
  end

  assign cleaned = (!s1_cmd_r.border && lone) ? '0 : win_nxt[4];

  always_comb begin
    if (s1_cmd_r.is_flush) begin
      pv = s1_cmd_r.sel_mid ? mid : up;
    end else begin
      pv = s1_cmd_r.use_corner ? corner : cleaned;
    end
    res.out_pixel     = (pv != '0) ? pv : fill;
    res.last_of_frame = s1_cmd_r.last;
  end

  assign oq_push   = s1_valid_r && s1_cmd_r.emit;
  assign out_empty = oq_cnt_r == '0;
  assign oq_pop    = out_pop && !out_empty;
  assign out_item  = oq_r[oq_rd_r];

  always_comb begin
    oq_wr_nxt = oq_wr_r;
    oq_rd_nxt = oq_rd_r;
    if (oq_push) begin
      oq_wr_nxt = (oq_wr_r == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 :
                  OUTQ_PTR_W'(oq_wr_r + OUTQ_PTR_W'(1));
    end
    if (oq_pop) begin
      oq_rd_nxt = (oq_rd_r == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 :
                  OUTQ_PTR_W'(oq_rd_r + OUTQ_PTR_W'(1));
    end
    case ({oq_push, oq_pop})
      2'b10:   oq_cnt_nxt = OUTQ_CNT_W'(oq_cnt_r + OUTQ_CNT_W'(1));
      2'b01:   oq_cnt_nxt = OUTQ_CNT_W'(oq_cnt_r - OUTQ_CNT_W'(1));
      default: oq_cnt_nxt = oq_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd_r <= q_head;
    end
    if (is_pix) begin
      lw_addr_r <= s1_cmd_r.col;
      lw_data_r <= {mid, s1_cmd_r.px};
    end
    if (oq_push) begin
      oq_r[oq_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      lw_valid_r <= 1'b0;
      oq_wr_r    <= '0;
      oq_rd_r    <= '0;
      oq_cnt_r   <= '0;
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      s1_valid_r <= q_pop;
      if (is_pix) begin
        lw_valid_r <= 1'b1;
        for (int k = 0; k < 9; k++) begin
          win_r[k] <= win_nxt[k];
        end
      end
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

`ifndef SYNTH
  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> (oq_cnt_r < OUTQ_CNT_W'(OUTQ_DEPTH)))
    else $error("result queue overflow");

  a_stage_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(q_pop))
    else $error("store stage loaded without a command");
`endif

endmodule

`default_nettype wire

/* rtl/isolated_pixel_removal_fill.sv */
// top level: configuration registers and the front, queue and back end
//
// Usage:
//   Input channel (in_push/in_full/in_item): one transaction per pixel in raster
//   order (opcode pixel), or a flush (opcode flush) after the last pixel of a
//   frame; each flush drains one pending result, flushes at other times do nothing.
//   Result channel (out_empty/out_pop/out_item): cleaned pixels in raster order,
//   zero pixels replaced by fill_value, last_of_frame marks the final pixel.
//   Configuration (cfg_we/cfg_index/cfg_data): 0 frame_width, 1 frame_height,
//   2 fill_value; write only while no transaction is in progress.
// Timing:
//   Results lag the pixel stream by one row plus one pixel. Inside the block a
//   transaction passes the command queue, the store stage and the result queue.
//   One transaction per cycle is sustained while the result queue has room; the line
//   store ram is read at dequeue and written in the next cycle, bypassed for that write.
// Reset:
//   Registers return to width 256, height 256, fill 5; positions and queues clear.
//   The line stores are not cleared and hold stale data until rewritten.
// Back-pressure:
//   When out_pop is held low the 4-entry result queue fills, the back end stops,
//   the 4-entry command queue fills and in_full rises.
`default_nettype none

module isolated_pixel_removal_fill import ipr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire in_item_t              in_item,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output out_item_t                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [FW_W-1:0]  frame_width_r;
  logic [FH_W-1:0]  frame_height_r;
  logic [PIX_W-1:0] fill_value_r;

  geom_t geom;
  logic  accept;
  logic  push;
  cmd_t  cmd;
  logic  q_pop;
  logic  q_valid;
  cmd_t  q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
      fill_value_r   <= FILL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        CFG_FILL_VALUE:   fill_value_r   <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (int'(frame_width_r) < MIN_DIM) begin
      geom.width = WID_W'(MIN_DIM);
    end else if (int'(frame_width_r) > MAX_WIDTH) begin
      geom.width = WID_W'(MAX_WIDTH);
    end else begin
      geom.width = WID_W'(frame_width_r);
    end
    if (int'(frame_height_r) < MIN_DIM) begin
      geom.height = ROW_W'(MIN_DIM);
    end else begin
      geom.height = ROW_W'(frame_height_r);
    end
  end

  assign accept = in_push && !in_full;

  ipr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .geom   (geom),
    .accept (accept),
    .item   (in_item),
    .push   (push),
    .cmd    (cmd)
  );

  ipr_cmd_q u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .cmd_in (cmd),
    .pop    (q_pop),
    .full   (in_full),
    .valid  (q_valid),
    .head   (q_head)
  );

  ipr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fill      (fill_value_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// testbench for isolated_pixel_removal_fill: directed and random frames checked by a predictor
module tb_top import ipr_pkg::*; ();

  localparam int IDLE_PCT = 19;
  localparam int SETTLE_CYCLES = 32;
  localparam int TOTAL_ITEMS = 650;
  localparam int MAX_REPORTS = 10;
  localparam int TIMEOUT_TICKS = 1200000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  isolated_pixel_removal_fill dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_item(in_item),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the registers and the streaming state
  logic [FW_W-1:0] width_reg = FW_RESET;
  logic [FH_W-1:0] height_reg = FH_RESET;
  logic [PIX_W-1:0] fill_reg = FILL_RESET;
  logic [PIX_W-1:0] upper_row [MAX_WIDTH];
  logic [PIX_W-1:0] middle_row [MAX_WIDTH];
  logic [PIX_W-1:0] window_px [9];
  int unsigned in_col = 0;
  int unsigned in_row = 0;
  int unsigned out_col = 0;
  int unsigned out_row = 0;

  in_item_t pixel_stream_q[$];
  out_item_t expected_pixels[$];
  int stim_count = 0;
  int error_count = 0;
  int send_idle_pct = IDLE_PCT;
  int recv_idle_pct = IDLE_PCT;

  function automatic int unsigned active_width();
    int unsigned w;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
  endfunction

  function automatic bit clean_and_fill(input in_item_t item, output out_item_t res);
    int unsigned w, h, r, c, orow, ocol;
    int k;
    logic [PIX_W-1:0] up, mid, corner, v;
    bit produced, lone;
    w = active_width();
    h = active_height();
    res = '0;
    produced = 1'b0;
    v = '0;
    if (item.opcode == OP_FLUSH) begin
      // drains only at a frame boundary while results are still owed
      if (in_row != 0 || in_col != 0 || (out_row == 0 && out_col == 0)) return 1'b0;
      r = out_row;
      c = (out_col < MAX_WIDTH) ? out_col : MAX_WIDTH - 1;
      v = (r + 1 < h) ? upper_row[c] : middle_row[c];
      res.last_of_frame = (r + 1 >= h) && (c + 1 >= w);
      if (c + 1 >= w) begin
        out_col = 0;
        out_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        out_col = c + 1;
      end
      produced = 1'b1;
    end else begin
      if (in_col >= w) begin
        in_col = 0;
        in_row = in_row + 1;
      end
      if (in_row >= h) in_row = 0;
      r = in_row;
      c = in_col;
      up = upper_row[c];
      mid = middle_row[c];
      corner = upper_row[w - 1];
      if (r == 0 && c == 0) begin
        out_row = 0;
        out_col = 0;
      end
      for (k = 0; k < 3; k++) begin
        window_px[3*k] = window_px[3*k + 1];
        window_px[3*k + 1] = window_px[3*k + 2];
      end
      window_px[2] = up;
      window_px[5] = mid;
      window_px[8] = item.pixel_in;
      upper_row[c] = mid;
      middle_row[c] = item.pixel_in;
      produced = (r >= 2) || (r == 1 && c >= 1);
      if (produced) begin
        if (c == 0) begin
          // first column closes out the last pixel of the row two above
          orow = r - 2;
          ocol = w - 1;
          v = corner;
        end else begin
          orow = r - 1;
          ocol = c - 1;
          v = window_px[4];
          if (orow != 0 && orow + 1 < h && ocol != 0 && ocol + 1 < w && v != 0) begin
            lone = 1'b1;
            for (k = 0; k < 9; k++) begin
              if (k != 4 && window_px[k] != 0) lone = 1'b0;
            end
            if (lone) v = '0;
          end
        end
        res.last_of_frame = (orow + 1 >= h) && (ocol + 1 >= w);
        if (ocol + 1 >= w) begin
          out_col = 0;
          out_row = orow + 1;
        end else begin
          out_col = ocol + 1;
          out_row = orow;
        end
      end
      if (c + 1 >= w) begin
        in_col = 0;
        in_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        in_col = c + 1;
      end
    end
    if (produced) res.out_pixel = (v != 0) ? v : fill_reg;
    return produced;
  endfunction

  function automatic void queue_item(input logic op, input logic [PIX_W-1:0] px);
    in_item_t item;
    item.opcode = op;
    item.pixel_in = px;
    pixel_stream_q.insert(pixel_stream_q.size(), item);
    stim_count++;
  endfunction

  // sparse edge content, with stray flushes inside the frame now and then
  function automatic void queue_pixels(input int unsigned count, input bit noisy);
    int unsigned i;
    logic [PIX_W-1:0] px;
    for (i = 0; i < count; i++) begin
      px = ($urandom_range(99) < 55) ? '0 : PIX_W'($urandom_range(255, 1));
      queue_item(OP_PIXEL, px);
      if (noisy && i + 1 < count && $urandom_range(99) < 5)
        queue_item(OP_FLUSH, PIX_W'($urandom));
    end
  endfunction

  function automatic void queue_flushes(input int unsigned count);
    repeat (count) queue_item(OP_FLUSH, PIX_W'($urandom));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_FRAME_WIDTH: width_reg = data[FW_W-1:0];
      CFG_FRAME_HEIGHT: height_reg = data[FH_W-1:0];
      CFG_FILL_VALUE: fill_reg = data[PIX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ignored items may still be in flight once the last result is back
  task automatic wait_drained();
    while (pixel_stream_q.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_n && pixel_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_push <= 1'b1;
      in_item <= pixel_stream_q[0];
    end else begin
      in_push <= 1'b0;
    end
    out_pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : monitor
    out_item_t predicted;
    out_item_t want;
    if (rst_n) begin
      if (in_push && !in_full) begin
        if (clean_and_fill(in_item, predicted))
          expected_pixels.insert(expected_pixels.size(), predicted);
        void'(pixel_stream_q.pop_front());
      end
      if (out_pop && !out_empty) begin
        if (expected_pixels.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("unexpected transaction: pixel %0d last %0b",
                     out_item.out_pixel, out_item.last_of_frame);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_item.out_pixel !== want.out_pixel ||
              out_item.last_of_frame !== want.last_of_frame) begin
            if (error_count < MAX_REPORTS)
              $display("mismatch: pixel exp %0d got %0d, last exp %0b got %0b",
                       want.out_pixel, out_item.out_pixel,
                       want.last_of_frame, out_item.last_of_frame);
            error_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned w, h, phase;
    logic [CFG_DATA_W-1:0] wdata, hdata, fdata;
    logic [PIX_W-1:0] fill_px;
    foreach (upper_row[i]) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    foreach (window_px[i]) window_px[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sizes below the minimum clamp to 3x3
    write_reg(CFG_FRAME_WIDTH, 12'd0);
    write_reg(CFG_FRAME_HEIGHT, 12'd2);
    write_reg(CFG_SPARE_INDEX, '1);
    queue_item(OP_FLUSH, 8'hFF);
    // lone center pixel is cleared, then every zero takes the fill
    queue_item(OP_PIXEL, 8'h00); queue_item(OP_PIXEL, 8'h00); queue_item(OP_PIXEL, 8'h00);
    queue_item(OP_PIXEL, 8'h00); queue_item(OP_PIXEL, 8'hFF); queue_item(OP_PIXEL, 8'h00);
    queue_item(OP_PIXEL, 8'h00); queue_item(OP_PIXEL, 8'h00); queue_item(OP_PIXEL, 8'h00);
    repeat (5) queue_item(OP_FLUSH, 8'h00);
    // center with a neighbor survives; mid-frame flush; next frame skips the drain
    queue_item(OP_PIXEL, 8'h01); queue_item(OP_PIXEL, 8'h00); queue_item(OP_PIXEL, 8'h80);
    queue_item(OP_PIXEL, 8'h00); queue_item(OP_PIXEL, 8'h5A); queue_item(OP_FLUSH, 8'h3C);
    queue_item(OP_PIXEL, 8'h00); queue_item(OP_PIXEL, 8'h40); queue_item(OP_PIXEL, 8'h00);
    queue_item(OP_PIXEL, 8'hFF);
    wait_drained();

    // widest rows and tallest frame, then shrunk in the middle of the second row
    write_reg(CFG_FRAME_WIDTH, '1);
    write_reg(CFG_FRAME_HEIGHT, '1);
    write_reg(CFG_FILL_VALUE, 12'($urandom));
    queue_pixels(MAX_WIDTH + 20, 1'b1);
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, 12'd8);
    write_reg(CFG_FRAME_HEIGHT, 12'd3);
    queue_pixels(8, 1'b1);
    queue_flushes(9);
    wait_drained();

    phase = 0;
    while (stim_count < TOTAL_ITEMS) begin
      wdata = {3'($urandom), ($urandom_range(99) < 10) ? 9'($urandom_range(2, 0))
                                                        : 9'($urandom_range(10, 3))};
      hdata = ($urandom_range(99) < 20) ? 12'($urandom_range(2, 0))
                                        : 12'($urandom_range(6, 3));
      fill_px = (phase == 3) ? 8'h00 : (phase == 4) ? 8'hFF : PIX_W'($urandom);
      fdata = {4'($urandom), fill_px};
      write_reg(CFG_FRAME_WIDTH, wdata);
      write_reg(CFG_FRAME_HEIGHT, hdata);
      write_reg(CFG_FILL_VALUE, fdata);
      send_idle_pct = (phase == 1) ? 0 : IDLE_PCT;
      recv_idle_pct = (phase == 1) ? 0 : IDLE_PCT;
      w = active_width();
      h = active_height();
      repeat ($urandom_range(3, 1)) begin
        queue_pixels(w * h, 1'b1);
        if ($urandom_range(99) < 85) begin
          queue_flushes(w + 1);
          repeat ($urandom_range(2, 0)) queue_item(OP_FLUSH, PIX_W'($urandom));
        end else begin
          // next frame starts before this one is fully drained
          queue_flushes($urandom_range(w, 0));
        end
        // sender holds off until every result is back
        if (phase == 2) wait_drained();
      end
      wait_drained();
      phase++;
    end

    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
    wait_drained();
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_TICKS;
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/ipr_pkg.sv
rtl/ipr_ram.sv
rtl/ipr_front.sv
rtl/ipr_cmd_q.sv
rtl/ipr_back.sv
rtl/isolated_pixel_removal_fill.sv
test/tb_top.sv
